// File: hw/rtl/alr_pkg.sv
// Shared constants and types for the additive lagged random generator.
`default_nettype none

package alr_pkg;

  // Store geometry and word widths.
  localparam int STORE_WORDS = 33;
  localparam int WORD_W      = 32;
  localparam int OUT_W       = 31;

  // The lag position starts here while the write position starts at the top word.
  localparam int LAG_START  = 12;
  // Both positions step together, so the lag word sits at a fixed distance in the ring.
  localparam int LAG_OFFSET = (STORE_WORDS - 1) - LAG_START;

  // Warm-up after a reseed.
  localparam int WARMUP_DRAWS = 10 * STORE_WORDS;
  localparam int FILL_CNT_W   = $clog2(STORE_WORDS);
  localparam int WARM_CNT_W   = $clog2(WARMUP_DRAWS);

  // Congruential fill constants.
  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd12345;

  // Store contents after reset, by store address.
  localparam logic [WORD_W-1:0] INIT_WORDS [STORE_WORDS] = '{
    32'hd53f1852, 32'hdfc78b83, 32'h4f256096, 32'h0e643df7,
    32'h82c359bf, 32'hc7794dfa, 32'hd5e9ffaa, 32'h2c8cb64a,
    32'h2f07b334, 32'had5a7eb5, 32'h96dc0cde, 32'h6fc24589,
    32'ha5853646, 32'he71576e2, 32'h0dae30df, 32'hb09ce711,
    32'h5e56ef87, 32'h4b4b0082, 32'h6f4f340e, 32'hc5bb17e8,
    32'hd788d765, 32'h67498087, 32'h9d7aba26, 32'h261351d4,
    32'h411ee7ea, 32'h0393a263, 32'h2c5a5835, 32'hc115fcd8,
    32'h25e9132c, 32'hd0c6e906, 32'hc2bc5b2d, 32'h6c065c98,
    32'h6e37bd55
  };

  // Item operation codes.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // What every cell of the ring does in a cycle.
  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_DRAW,
    SHIFT_FILL
  } shift_mode_t;

endpackage

`default_nettype wire

// File: hw/rtl/alr_cell.sv
// One word cell of the generator ring.
`default_nettype none

module alr_cell
  import alr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WORD_W-1:0] init_word,
  input  wire shift_mode_t       mode,
  input  wire logic [WORD_W-1:0] upper_word,
  input  wire logic [WORD_W-1:0] lower_word,
  output logic      [WORD_W-1:0] word
);

  // A draw takes the word from the cell above; a fill takes it from the cell below.
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= init_word;
    end else begin
      unique case (mode)
        SHIFT_HOLD: word <= word;
        SHIFT_DRAW: word <= upper_word;
        SHIFT_FILL: word <= lower_word;
        default:    word <= word;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/additive_lagged_random_generator_core.sv
// Top level of the additive lagged random generator: control, adder and cell ring.
//
//   channel  | direction | handshake                  | words
//   ---------+-----------+----------------------------+-------------------------
//   item     | in        | item_valid / item_ready    | op, seed_value
//   result   | out       | result_valid / result_ready| random_value (draws only)
//
// On a draw the adder reads the head cell and the lag cell and the ring rotates by one
// cell, so draws are taken back to back while the result register drains.
// A reseed pushes the seed in its accepting cycle, then fills the other 32 words through the
// congruential multiplier and runs 330 warm-up draws; item_ready stays low until they end.
// Reset loads the fixed initial store into the cells; no clearing pass follows.
// A result held by a low result_ready stalls the item channel for any word, draw or reseed.
`default_nettype none

module additive_lagged_random_generator_core
  import alr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire logic             op,
  input  wire logic [WORD_W-1:0] seed_value,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic      [OUT_W-1:0] random_value
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_WARM
  } state_t;

  state_t                  state;
  logic [FILL_CNT_W-1:0]   fill_cnt;
  logic [WARM_CNT_W-1:0]   warm_cnt;
  logic [WORD_W-1:0]       lcg_word;

  logic [WORD_W-1:0] ring [STORE_WORDS];
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] lcg_next;
  logic [WORD_W-1:0] fill_word;
  logic              item_take;
  logic              draw_take;
  logic              reseed_take;
  shift_mode_t       mode;

  // Handshake decode.
  assign item_ready  = (state == ST_IDLE) && (!result_valid || result_ready);
  assign item_take   = item_valid && item_ready;
  assign draw_take   = item_take && (op == OP_DRAW);
  assign reseed_take = item_take && (op == OP_RESEED);

  // The head cell holds the write word; the lag word sits a fixed distance down the ring.
  assign sum = ring[0] + ring[LAG_OFFSET];

  // Next congruential word, chained from the last word pushed into the ring.
  assign lcg_next  = lcg_word * LCG_MUL + LCG_ADD;
  assign fill_word = (state == ST_FILL) ? lcg_next : seed_value;

  // Ring mode for this cycle.
  always_comb begin
    if (draw_take || (state == ST_WARM)) begin
      mode = SHIFT_DRAW;
    end else if (reseed_take || (state == ST_FILL)) begin
      mode = SHIFT_FILL;
    end else begin
      mode = SHIFT_HOLD;
    end
  end

  // Row of cells: draws rotate towards the head, fills push in at the head.
  for (genvar k = 0; k < STORE_WORDS; k++) begin : g_cell
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] lower;

    if (k == STORE_WORDS - 1) begin : g_top
      assign upper = sum;
    end else begin : g_mid_up
      assign upper = ring[k+1];
    end

    if (k == 0) begin : g_head
      assign lower = fill_word;
    end else begin : g_mid_down
      assign lower = ring[k-1];
    end

    alr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .init_word  (INIT_WORDS[STORE_WORDS-1-k]),
      .mode       (mode),
      .upper_word (upper),
      .lower_word (lower),
      .word       (ring[k])
    );
  end

  // Sequencer, fill chain and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_cnt     <= '0;
      warm_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (draw_take) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (draw_take) begin
            random_value <= sum[WORD_W-1:1];
          end else if (reseed_take) begin
            lcg_word <= seed_value;
            fill_cnt <= FILL_CNT_W'(1);
            state    <= ST_FILL;
          end
        end
        ST_FILL: begin
          lcg_word <= lcg_next;
          if (fill_cnt == FILL_CNT_W'(STORE_WORDS - 1)) begin
            warm_cnt <= '0;
            state    <= ST_WARM;
          end else begin
            fill_cnt <= fill_cnt + FILL_CNT_W'(1);
          end
        end
        ST_WARM: begin
          if (warm_cnt == WARM_CNT_W'(WARMUP_DRAWS - 1)) begin
            state <= ST_IDLE;
          end else begin
            warm_cnt <= warm_cnt + WARM_CNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/alr_checker.sv
// Port-level checks for the additive lagged random generator, bound to its top level.
`default_nettype none

module alr_checker
  import alr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              op,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire logic [OUT_W-1:0]  random_value
);

  // A result word that is not taken stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its value.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(random_value))
    else $error("result word changed while stalled");

  // A draw gives a result word in the next cycle.
  a_draw_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (op == OP_DRAW) |=> result_valid)
    else $error("draw word gave no result");

  // A reseed occupies the generator in the following cycle.
  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (op == OP_RESEED) |=> !item_ready)
    else $error("generator ready straight after a reseed");

  // A reseed gives no result word of its own.
  a_reseed_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (op == OP_RESEED) && !result_valid |=> !result_valid)
    else $error("reseed produced a result word");

endmodule

bind additive_lagged_random_generator_core alr_checker u_alr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .op           (op),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .random_value (random_value)
);

`default_nettype wire

// File: test/additive_lagged_random_generator_core_tb.sv
// Self-checking testbench for the additive lagged random generator core with a reference predictor.
module additive_lagged_random_generator_core_tb
  import alr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int END_WAIT       = 400;
  localparam int PHASE_WORDS    = 200;

  // One input word waiting to be sent, with the idling that applies while it is offered.
  typedef struct {
    logic              op;
    logic [WORD_W-1:0] seed;
    int unsigned       send_pct;
    int unsigned       recv_pct;
    bit                drain_first;
    bit                hold;
  } item_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic              op = OP_DRAW;
  logic [WORD_W-1:0] seed_value = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [OUT_W-1:0]  random_value;

  // Predicted generator state.
  logic [WORD_W-1:0] gen_store [STORE_WORDS];
  int unsigned       gen_write_pos;
  int unsigned       gen_lag_pos;

  item_word_t        pending_words[$];
  logic [OUT_W-1:0]  expected_values[$];
  int unsigned       issued_draws = 0;
  int unsigned       got_results = 0;
  int unsigned       recv_pct = 0;
  logic              hold_start = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       mismatches = 0;
  int unsigned       idle_cycles = 0;

  additive_lagged_random_generator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .seed_value   (seed_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .random_value (random_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Both positions walk downward and wrap from the bottom to the top word.
  function automatic int unsigned step_down(int unsigned pos);
    return (pos == 0 || pos >= STORE_WORDS) ? STORE_WORDS - 1 : pos - 1;
  endfunction

  // Add the lag word into the write word and return the upper 31 bits of the sum.
  function automatic logic [OUT_W-1:0] next_draw();
    logic [WORD_W-1:0] sum;
    sum = gen_store[gen_write_pos] + gen_store[gen_lag_pos];
    gen_store[gen_write_pos] = sum;
    gen_write_pos = step_down(gen_write_pos);
    gen_lag_pos   = step_down(gen_lag_pos);
    return sum[WORD_W-1:1];
  endfunction

  // Congruential fill from the seed, then the discarded warm-up draws.
  task automatic reseed_model(input logic [WORD_W-1:0] seed);
    gen_store[0] = seed;
    for (int i = 1; i < STORE_WORDS; i++)
      gen_store[i] = gen_store[i-1] * LCG_MUL + LCG_ADD;
    gen_write_pos = STORE_WORDS - 1;
    gen_lag_pos   = LAG_START;
    for (int i = 0; i < WARMUP_DRAWS; i++)
      void'(next_draw());
  endtask

  task automatic add_word(input logic wop, input logic [WORD_W-1:0] seed,
                          input int unsigned send, input int unsigned recv,
                          input bit drain, input bit hold);
    item_word_t w;
    w.op = wop;
    w.seed = seed;
    w.send_pct = send;
    w.recv_pct = recv;
    w.drain_first = drain;
    w.hold = hold;
    pending_words.push_back(w);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < 10)
      $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  // Driver: predict each accepted word, then offer the next one when the slot is free.
  always @(posedge clk) begin
    item_word_t head;
    bit slot_free;
    bit drained;
    bit hold_now;
    if (rst) begin
      item_valid <= 1'b0;
      hold_start <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        if (op == OP_RESEED) begin
          reseed_model(seed_value);
        end else begin
          expected_values.push_back(next_draw());
          issued_draws++;
        end
      end
      slot_free = !item_valid || item_ready;
      drained = (issued_draws == got_results);
      hold_now = 1'b0;
      if (slot_free) begin
        if (pending_words.size() != 0 && (!pending_words[0].drain_first || drained) &&
            $urandom_range(99) >= pending_words[0].send_pct) begin
          head = pending_words.pop_front();
          item_valid <= 1'b1;
          op <= head.op;
          seed_value <= head.seed;
          recv_pct <= head.recv_pct;
          hold_now = head.hold;
        end else begin
          item_valid <= 1'b0;
        end
      end
      hold_start <= hold_now;
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction, and drive ready.
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      result_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (result_valid && result_ready) begin
        got_results <= got_results + 1;
        if (expected_values.size() == 0) begin
          flag_mismatch($sformatf("unexpected random_value %h", random_value));
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want)
            flag_mismatch($sformatf("random_value expected %h, got %h", want, random_value));
        end
      end
      // A long hold-off lets the result side back up into the item channel.
      if (hold_start)
        hold_left <= LONG_HOLD;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
      result_ready <= (hold_start || hold_left > 1) ? 1'b0 : ($urandom_range(99) >= recv_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned send_mix [4];
    int unsigned recv_mix [4];
    logic [WORD_W-1:0] seed;
    send_mix = '{0, 53, 0, 22};
    recv_mix = '{0, 0, 53, 22};

    for (int i = 0; i < STORE_WORDS; i++)
      gen_store[i] = INIT_WORDS[i];
    gen_write_pos = STORE_WORDS - 1;
    gen_lag_pos   = LAG_START;

    // Draws from the reset store; the seed field must be ignored on a draw.
    add_word(OP_DRAW, 32'h0000_0000, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'hffff_ffff, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'h5555_5555, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'haaaa_aaaa, 0, 0, 0, 0);
    // Reseeds with the extreme seeds, each followed by draws.
    add_word(OP_RESEED, 32'h0000_0000, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'h0000_0000, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'hffff_ffff, 0, 0, 0, 0);
    add_word(OP_RESEED, 32'hffff_ffff, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'h0000_0000, 0, 0, 0, 0);
    add_word(OP_RESEED, 32'h8000_0000, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'h0000_0000, 0, 0, 0, 0);
    // Two reseeds back to back: only the second one matters.
    add_word(OP_RESEED, 32'h0000_0001, 0, 0, 0, 0);
    add_word(OP_RESEED, 32'h7fff_ffff, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'h1234_5678, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'h0000_0000, 0, 0, 0, 0);
    add_word(OP_DRAW, 32'hffff_ffff, 0, 0, 0, 0);

    // Random phases, mostly draws with the odd reseed, under different idling.
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(39) == 0) begin
          case ($urandom_range(3))
            0: seed = '0;
            1: seed = '1;
            default: seed = $urandom;
          endcase
          add_word(OP_RESEED, seed, send_mix[p], recv_mix[p], i == 0 || (p == 3 && i == 100),
                   1'b0);
        end else begin
          add_word(OP_DRAW, $urandom, send_mix[p], recv_mix[p], i == 0 || (p == 3 && i == 100),
                   p == 0 && i == 50);
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be sent and every predicted result to come back.
    do
      @(negedge clk);
    while (pending_words.size() != 0 || item_valid || issued_draws != got_results);
    repeat (END_WAIT) @(posedge clk);

    if (expected_values.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived", expected_values.size()));

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
